// ----- sv/bra_pkg.sv -----
// bra_pkg: shared constants, types and command codes for the bitmap run allocator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package bra_pkg;

   localparam int MAP_BYTES     = 512;
   localparam int BITS_PER_BYTE = 8;
   localparam int ADDR_W        = $clog2(MAP_BYTES);       // byte address
   localparam int SPAN_W        = $clog2(MAP_BYTES + 1);   // byte count incl. MAP_BYTES
   localparam int BIT_W         = 12;                      // page bit index
   localparam int LEN_W         = 13;                      // run length
   localparam int CMD_W         = 2;

   localparam logic [BITS_PER_BYTE-1:0] FULL_BYTE = 8'hff;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [BIT_W-1:0]  bit_idx_type;
   typedef logic [SPAN_W-1:0] span_type;

   localparam cmd_type CMD_SEARCH = 2'd0;
   localparam cmd_type CMD_WRITE  = 2'd1;
   localparam cmd_type CMD_READ   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_ACCESS,
      ST_RESULT
   } state_type;

   // running state of the free-run scan
   typedef struct packed {
      len_type     run;
      bit_idx_type start;
      logic        found;
   } scan_type;

endpackage

// ----- sv/bra_req_if.sv -----
// bra_req_if: request channel (valid/ready plus command payload).
// Depends on bra_pkg.
`timescale 1ns / 1ps

interface bra_req_if;
   import bra_pkg::*;

   logic        valid;
   logic        ready;
   cmd_type     command;
   len_type     run_length;
   bit_idx_type page_index;
   logic        bit_value;

   modport source (output valid, command, run_length, page_index, bit_value, input ready);
   modport sink   (input valid, command, run_length, page_index, bit_value, output ready);
endinterface

// ----- sv/bra_rsp_if.sv -----
// bra_rsp_if: response channel (valid/ready plus result payload).
// Depends on bra_pkg.
`timescale 1ns / 1ps

interface bra_rsp_if;
   import bra_pkg::*;

   logic        valid;
   logic        ready;
   logic        status;
   bit_idx_type run_start;
   logic        bit_read;

   modport source (output valid, status, run_start, bit_read, input ready);
   modport sink   (input valid, status, run_start, bit_read, output ready);
endinterface

// ----- sv/bra_scan_step.sv -----
// bra_scan_step: advances the free-run scan across one bitmap byte, lowest bit first.
// Depends on bra_pkg.
`timescale 1ns / 1ps

module bra_scan_step (
   input  logic [bra_pkg::BITS_PER_BYTE-1:0] byte_data,
   input  logic [bra_pkg::ADDR_W-1:0]        byte_addr,
   input  bra_pkg::len_type                  want,
   input  bra_pkg::scan_type                 scan_in,
   output bra_pkg::scan_type                 scan_out
);
   import bra_pkg::*;

   always_comb begin
      scan_type s;
      s = scan_in;
      for (int b = 0; b < BITS_PER_BYTE; b++) begin
         if (!s.found) begin
            if (byte_data[b]) begin
               s.run = '0;
            end else begin
               if (s.run == '0) begin
                  s.start = {byte_addr, 3'(b)};
               end
               s.run = s.run + 1'b1;
               if (s.run == want) begin
                  s.found = 1'b1;
               end
            end
         end
      end
      scan_out = s;
   end

endmodule

// ----- sv/bitmap_run_allocator.sv -----
// bitmap_run_allocator: first-fit page allocator over a byte-wide usage bitmap.
// Depends on bra_pkg, bra_req_if, bra_rsp_if and bra_scan_step.
`timescale 1ns / 1ps

// The bitmap holds one bit per page (set = used) in a 512 x 8 RAM; page i is bit i%8 of
// byte i/8. A search request returns the start of the lowest run of run_length clear
// bits within the first bytes_in_use bytes (capped at 512), or status 1 when no run fits
// or run_length is zero. Write requests set or clear one bit, read requests return one.
// One request is in flight at a time; the block takes the next request while the previous
// response still waits in the output register. A search walks the RAM one byte a cycle
// through a single scan unit (address issue, then the scan of the registered byte) and
// stops early once a run is found; a zero length or zero span goes straight to the result
// state. Write and read first read the RAM byte on the accepting edge, then modify or
// select the bit, then load the response. The block returns to idle as the response is
// loaded; a stalled output register holds the block in its result state. After reset a
// clearing pass zeroes all 512 RAM bytes, during which req ready is low; csr writes are
// accepted at any time but must only change while the block is idle.

module bitmap_run_allocator (
   input  logic                     clock,
   input  logic                     reset,
   bra_req_if.sink                  req_chan,
   bra_rsp_if.source                rsp_chan,
   input  logic                     csr_wr_en,
   input  logic [bra_pkg::SPAN_W-1:0] csr_wr_data
);
   import bra_pkg::*;

   // bitmap RAM, registered read
   logic [BITS_PER_BYTE-1:0] mem [MAP_BYTES];
   logic [BITS_PER_BYTE-1:0] mem_rdata_ff;
   logic [ADDR_W-1:0]        mem_raddr, mem_waddr;
   logic [BITS_PER_BYTE-1:0] mem_wdata;
   logic                     mem_we;

   // control
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   span_type          bytes_in_use_ff;

   // request context
   len_type           want_ff, want_in;
   span_type          span_ff, span_in;
   cmd_type           cmd_ff, cmd_in;
   bit_idx_type       idx_ff, idx_in;
   logic              val_ff, val_in;

   // scan pipeline: issue address, then process the registered byte in the next cycle
   span_type          addr_ff, addr_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0] proc_idx_ff, proc_idx_in;
   scan_type          scan_ff, scan_in, scan_next;

   // pending result and output register
   logic              res_status_ff, res_status_in;
   bit_idx_type       res_start_ff, res_start_in;
   logic              res_bit_ff, res_bit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   bit_idx_type       rsp_start_ff, rsp_start_in;
   logic              rsp_bit_ff, rsp_bit_in;

   logic              req_fire;
   span_type          span_now;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // span capped at the store size
   assign span_now = (bytes_in_use_ff > SPAN_W'(MAP_BYTES)) ? SPAN_W'(MAP_BYTES)
                                                            : bytes_in_use_ff;

   bra_scan_step u_scan (
      .byte_data (mem_rdata_ff),
      .byte_addr (proc_idx_ff),
      .want      (want_ff),
      .scan_in   (scan_ff),
      .scan_out  (scan_next)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_cnt_ff      <= '0;
         bytes_in_use_ff <= SPAN_W'(MAP_BYTES);
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            bytes_in_use_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      want_ff       <= want_in;
      span_ff       <= span_in;
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      addr_ff       <= addr_in;
      proc_idx_ff   <= proc_idx_in;
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_bit_ff    <= res_bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_bit_ff    <= rsp_bit_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      want_in       = want_ff;
      span_in       = span_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      addr_in       = addr_ff;
      rd_valid_in   = 1'b0;
      proc_idx_in   = proc_idx_ff;
      scan_in       = scan_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_bit_in    = res_bit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_bit_in    = rsp_bit_ff;
      mem_raddr     = addr_ff[ADDR_W-1:0];
      mem_waddr     = idx_ff[BIT_W-1:3];
      mem_wdata     = mem_rdata_ff;
      mem_we        = 1'b0;

      // output register drains independently
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(MAP_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            mem_raddr = req_chan.page_index[BIT_W-1:3];
            if (req_fire) begin
               cmd_in        = req_chan.command;
               want_in       = req_chan.run_length;
               idx_in        = req_chan.page_index;
               val_in        = req_chan.bit_value;
               span_in       = span_now;
               addr_in       = '0;
               scan_in       = '0;
               res_status_in = 1'b0;
               res_start_in  = '0;
               res_bit_in    = 1'b0;
               case (req_chan.command) inside
                  CMD_SEARCH: begin
                     if (req_chan.run_length == '0 || span_now == '0) begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESULT;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  CMD_WRITE, CMD_READ: state_in = ST_ACCESS;
                  default:             state_in = ST_RESULT;  // unused code: no effect
               endcase
            end
         end

         ST_SEARCH: begin
            // issue next byte
            if (addr_ff < span_ff) begin
               rd_valid_in = 1'b1;
               proc_idx_in = addr_ff[ADDR_W-1:0];
               addr_in     = addr_ff + 1'b1;
            end
            // consume the byte read last cycle
            if (rd_valid_ff) begin
               scan_in = scan_next;
               if (scan_next.found) begin
                  res_start_in = scan_next.start;
                  rd_valid_in  = 1'b0;
                  state_in     = ST_RESULT;
               end
            end else if (addr_ff >= span_ff) begin
               res_status_in = 1'b1;
               state_in      = ST_RESULT;
            end
         end

         ST_ACCESS: begin
            if (cmd_ff == CMD_WRITE) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata_ff;
               mem_wdata[idx_ff[2:0]] = val_ff;
            end else begin
               res_bit_in = mem_rdata_ff[idx_ff[2:0]];
            end
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_bit_in    = res_bit_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.run_start = rsp_start_ff;
   assign rsp_chan.bit_read  = rsp_bit_ff;

   // RAM is only written by the clearing pass or a write request
   a_mem_we_src: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_ACCESS))
      else $error("bitmap written outside clear or write access");

   // an accepted request always leaves idle
   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // a found run starts inside the searched span
   a_run_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && rd_valid_ff && scan_next.found)
         |-> (SPAN_W'(scan_next.start[BIT_W-1:3]) < span_ff))
      else $error("run start beyond searched span");

   // a pending response is never overwritten before it is taken
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(rsp_start_ff)))
      else $error("response register overwritten while stalled");

endmodule

// ----- tb/sv/bitmap_run_allocator_tb.sv -----
// bitmap_run_allocator_tb: self-checking bench for the first-fit page bitmap allocator.
// Depends on bra_pkg, bra_req_if, bra_rsp_if and the bitmap_run_allocator RTL.
`timescale 1ns / 1ps

module bitmap_run_allocator_tb;
   import bra_pkg::*;

   // command code 3 has no meaning; the block must answer all zeros and leave the map alone
   localparam cmd_type CMD_UNUSED = 2'd3;

   localparam int NO_CSR        = -1;    // table rows that keep the current search span
   localparam int CLK_HALF      = 2;
   localparam int RESET_CYCLES  = 7;
   localparam int LONG_HOLD     = 400;   // response back-pressure long enough to fill the block
   localparam int QUIET_LIMIT   = 6000;  // cycles without any handshake before giving up
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS   = 115;
   localparam int N_PHASES      = 10;
   localparam int N_DIRECTED    = 24;
   localparam int MAX_MARK      = 24;    // pages marked used after a successful search
   localparam int MAX_SHOWN     = 10;
   localparam int PAGE_TOP      = 4095;
   localparam int LEN_TOP       = 8191;

   typedef struct packed {
      logic        status;
      bit_idx_type run_start;
      logic        bit_read;
   } alloc_reply_type;

   typedef struct {
      int      csr;     // span written before the row, NO_CSR to keep it
      cmd_type cmd;
      int      len;
      int      idx;
      bit      val;
      bit      fixed;   // reply typed in below rather than taken from the predictor
      bit      status;
      int      start;
      bit      rd;
   } directed_row_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [SPAN_W-1:0]   csr_wr_data;

   bra_req_if req_if ();
   bra_rsp_if rsp_if ();

   bitmap_run_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------------------------
   // Predictor state: private copy of the page map and of the search span register
   // ---------------------------------------------------------------------------------------
   logic [BITS_PER_BYTE-1:0] page_map [MAP_BYTES];
   int unsigned              search_bytes;
   alloc_reply_type          pending_replies [$];   // replies owed by the block, oldest first
   int                       mismatches;
   bit                       quiet;                 // no idling on either side
   bit                       hold_request;          // asks the response side for a long stall

   // directed rows: reset state, field extremes, every command, span extremes
   directed_row_type directed_rows [N_DIRECTED] = '{
      // fresh map: page 0 is the first free page
      '{NO_CSR, CMD_SEARCH,    1,    0, 0, 1, 0, 0, 0},
      // zero length never succeeds
      '{NO_CSR, CMD_SEARCH,    0,    0, 0, 1, 1, 0, 0},
      // whole map is one free run
      '{NO_CSR, CMD_SEARCH, 4096, 4095, 1, 1, 0, 0, 0},
      '{NO_CSR, CMD_SEARCH, 8191,    0, 0, 1, 1, 0, 0},
      '{NO_CSR, CMD_READ,      0, 4095, 0, 1, 0, 0, 0},
      '{NO_CSR, CMD_WRITE,     0,    0, 1, 1, 0, 0, 0},
      '{NO_CSR, CMD_READ,   8191,    0, 1, 1, 0, 0, 1},
      '{NO_CSR, CMD_SEARCH,    1,    0, 0, 1, 0, 1, 0},
      '{NO_CSR, CMD_WRITE,     0, 4095, 1, 1, 0, 0, 0},
      '{NO_CSR, CMD_SEARCH, 4095,    0, 0, 0, 0, 0, 0},
      '{NO_CSR, CMD_SEARCH, 4094,    0, 0, 0, 0, 0, 0},
      // unused command with every field at its top
      '{NO_CSR, CMD_UNUSED, 8191, 4095, 1, 1, 0, 0, 0},
      '{NO_CSR, CMD_READ,      0, 4095, 0, 1, 0, 0, 1},
      // empty span: nothing to search
      '{0,      CMD_SEARCH,    1,    0, 0, 1, 1, 0, 0},
      // write/read outside the search span still reach the store
      '{NO_CSR, CMD_WRITE,     0, 2000, 1, 1, 0, 0, 0},
      '{NO_CSR, CMD_READ,      0, 2000, 0, 1, 0, 0, 1},
      // one byte span: a run may not spill past page 7
      '{1,      CMD_SEARCH,    7,    0, 0, 0, 0, 0, 0},
      '{NO_CSR, CMD_SEARCH,    8,    0, 0, 0, 0, 0, 0},
      // oversized span is clipped to the store
      '{1023,   CMD_SEARCH,    2,    0, 0, 0, 0, 0, 0},
      '{NO_CSR, CMD_WRITE,     0,    0, 0, 1, 0, 0, 0},
      '{NO_CSR, CMD_WRITE,     0, 4095, 0, 1, 0, 0, 0},
      '{NO_CSR, CMD_WRITE,     0, 2000, 0, 1, 0, 0, 0},
      '{512,    CMD_SEARCH, 4096,    0, 0, 1, 0, 0, 0},
      '{NO_CSR, CMD_SEARCH, 4097,    0, 0, 1, 1, 0, 0}
   };

   // search spans per random phase, extremes included
   int phase_bytes [N_PHASES] = '{512, 2, 1, 1023, 37, 0, 600, 3, 512, 128};

   function automatic int unsigned covered_bytes();
      return (search_bytes > MAP_BYTES) ? MAP_BYTES : search_bytes;
   endfunction

   function automatic bit page_used(int unsigned page);
      if (page / BITS_PER_BYTE >= MAP_BYTES)
         return 1'b0;
      return page_map[page / BITS_PER_BYTE][page % BITS_PER_BYTE];
   endfunction

   // first fit: skip full bytes, find the lowest free page, then walk for a long enough run
   function automatic bit find_free_run(int unsigned want, output int unsigned start);
      int unsigned span;
      int unsigned byte_no;
      int unsigned first;
      int unsigned limit;
      int unsigned run;
      int unsigned page;
      span  = covered_bytes();
      start = 0;
      if (want == 0)
         return 1'b0;
      byte_no = 0;
      while (byte_no < span && page_map[byte_no] == FULL_BYTE)
         byte_no++;
      if (byte_no >= span)
         return 1'b0;
      first = byte_no * BITS_PER_BYTE;
      while (page_used(first))
         first++;
      if (want == 1) begin
         start = first;
         return 1'b1;
      end
      limit = span * BITS_PER_BYTE;
      run   = 1;
      for (page = first + 1; page < limit; page++) begin
         run = page_used(page) ? 0 : run + 1;
         if (run == want) begin
            start = page + 1 - want;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // reply for one accepted request; updates the private map as the block should
   function automatic alloc_reply_type predict_reply(cmd_type cmd, len_type len,
                                                     bit_idx_type idx, logic val);
      alloc_reply_type reply;
      int unsigned     start;
      reply = '0;
      case (cmd)
         CMD_SEARCH: begin
            if (find_free_run(len, start))
               reply.run_start = bit_idx_type'(start);
            else
               reply.status = 1'b1;
         end
         CMD_WRITE: begin
            if (idx / BITS_PER_BYTE < MAP_BYTES)
               page_map[idx / BITS_PER_BYTE][idx % BITS_PER_BYTE] = val;
         end
         CMD_READ: begin
            reply.bit_read = page_used(idx);
         end
         default: ;
      endcase
      return reply;
   endfunction

   // mostly back to back, some short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned pick_run_length(int unsigned span_pages);
      int unsigned top;
      int          r;
      top = (span_pages > 0) ? span_pages + 1 : 2;
      r   = $urandom_range(0, 99);
      if (r < 5)
         return 0;
      if (r < 55)
         return $urandom_range(1, 8);
      if (r < 80)
         return $urandom_range(9, 64);
      if (r < 92)
         return $urandom_range(1, top);
      if (r < 96)
         return $urandom_range(4095, 4097);
      return $urandom_range(0, LEN_TOP);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side. Valid stays high between back-to-back requests and only drops for a gap,
   // so it never sees two assignments in one time step.
   // ---------------------------------------------------------------------------------------
   task automatic issue_request(input cmd_type cmd, input int unsigned len,
                                input int unsigned idx, input bit val, input bit fixed,
                                input alloc_reply_type fixed_reply,
                                output alloc_reply_type reply);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.run_length <= len_type'(len);
      req_if.page_index <= bit_idx_type'(idx);
      req_if.bit_value  <= val;
      do @(posedge clock); while (!req_if.ready);
      reply = predict_reply(cmd, len_type'(len), bit_idx_type'(idx), val);
      pending_replies.push_back(fixed ? fixed_reply : reply);
   endtask

   task automatic send_op(input cmd_type cmd, input int unsigned len, input int unsigned idx,
                          input bit val, output alloc_reply_type reply);
      issue_request(cmd, len, idx, val, 1'b0, '0, reply);
   endtask

   // sender pauses until every owed reply has come back
   task automatic wait_replies_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   // only called with nothing in flight
   task automatic write_search_bytes(input int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= span_type'(value);
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      search_bytes = value & ((1 << SPAN_W) - 1);
   endtask

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Response side: check each reply against the oldest expectation, then decide ready.
   // Values are read straight after the edge, before any of this step's updates land.
   // ---------------------------------------------------------------------------------------
   initial begin : reply_side
      int              stall_left;
      alloc_reply_type seen;
      alloc_reply_type owed;
      stall_left   = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            seen = {rsp_if.status, rsp_if.run_start, rsp_if.bit_read};
            if (pending_replies.size() == 0) begin
               if (mismatches < MAX_SHOWN)
                  $display("%0t: reply with none owed: status %0d start %0d bit %0d",
                           $time, seen.status, seen.run_start, seen.bit_read);
               mismatches++;
            end else begin
               owed = pending_replies.pop_front();
               if (seen.status !== owed.status || seen.run_start !== owed.run_start ||
                   seen.bit_read !== owed.bit_read) begin
                  if (mismatches < MAX_SHOWN)
                     $display("%0t: reply mismatch: want status %0d start %0d bit %0d, %s",
                              $time, owed.status, owed.run_start, owed.bit_read,
                              $sformatf("got status %0d start %0d bit %0d",
                                        seen.status, seen.run_start, seen.bit_read));
                  mismatches++;
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // watchdog: nothing accepted on either channel for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[bitmap_run_allocator] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus: directed table, then random phases at different search spans
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      directed_row_type d;
      alloc_reply_type  reply;
      alloc_reply_type  fixed_reply;
      cmd_type          cmd;
      int               row;
      int               phase;
      int               phase_items;
      int               pick;
      int               k;
      int               nmark;
      int unsigned      eff;
      int unsigned      span_pages;
      int unsigned      range_hi;
      int unsigned      len;
      int unsigned      base;
      bit               held;
      bit               paused;

      mismatches   = 0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      search_bytes = MAP_BYTES;
      foreach (page_map[i])
         page_map[i] = '0;

      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      req_if.valid          <= 1'b0;
      req_if.command        <= CMD_SEARCH;
      req_if.run_length     <= '0;
      req_if.page_index     <= '0;
      req_if.bit_value      <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // the block runs its clearing pass first; ready stays low until it is done
      for (row = 0; row < N_DIRECTED; row++) begin
         d = directed_rows[row];
         if (d.csr != NO_CSR) begin
            wait_replies_drained();
            write_search_bytes(d.csr);
         end
         fixed_reply = {d.status, bit_idx_type'(d.start), d.rd};
         issue_request(d.cmd, d.len, d.idx, d.val, d.fixed, fixed_reply, reply);
      end

      for (phase = 0; phase < N_PHASES; phase++) begin
         wait_replies_drained();
         write_search_bytes(phase_bytes[phase]);
         quiet       = (phase == 3 || phase == 7);
         eff         = covered_bytes();
         span_pages  = eff * BITS_PER_BYTE;
         range_hi    = (span_pages > 0) ? span_pages - 1 : PAGE_TOP;
         phase_items = 0;
         held        = 1'b0;
         paused      = 1'b0;

         while (phase_items < PHASE_ITEMS) begin
            // long response stall while requests keep coming
            if (!held && phase_items >= 50 && (phase == 0 || phase == 8)) begin
               held         = 1'b1;
               hold_request = 1'b1;
            end
            if (!paused && phase_items >= 60 && phase == 4) begin
               paused = 1'b1;
               wait_replies_drained();
            end

            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               // allocation: search, then mark up to MAX_MARK pages of the run used as software would
               len = pick_run_length(span_pages);
               send_op(CMD_SEARCH, len, $urandom_range(0, PAGE_TOP), $urandom_range(0, 1),
                       reply);
               phase_items++;
               if (!reply.status) begin
                  base  = reply.run_start;
                  nmark = (len < MAX_MARK) ? len : MAX_MARK;
                  for (k = 0; k < nmark; k++) begin
                     send_op(CMD_WRITE, $urandom_range(0, LEN_TOP), (base + k) & PAGE_TOP,
                             1'b1, reply);
                     phase_items++;
                  end
               end
            end else if (pick < 55) begin
               // release a short stretch of pages
               base  = $urandom_range(0, range_hi);
               nmark = $urandom_range(1, 12);
               for (k = 0; k < nmark; k++) begin
                  send_op(CMD_WRITE, $urandom_range(0, LEN_TOP), (base + k) & PAGE_TOP,
                          1'b0, reply);
                  phase_items++;
               end
            end else if (pick < 62) begin
               // fill a whole byte so the scan has full bytes to skip
               base = $urandom_range(0, (eff > 0) ? eff - 1 : MAP_BYTES - 1);
               for (k = 0; k < BITS_PER_BYTE; k++) begin
                  send_op(CMD_WRITE, 0, base * BITS_PER_BYTE + k, 1'b1, reply);
                  phase_items++;
               end
            end else if (pick < 80) begin
               send_op(CMD_SEARCH, pick_run_length(span_pages), $urandom_range(0, PAGE_TOP),
                       $urandom_range(0, 1), reply);
               phase_items++;
            end else if (pick < 92) begin
               base = ($urandom_range(0, 9) < 8) ? $urandom_range(0, range_hi)
                                                 : $urandom_range(0, PAGE_TOP);
               send_op(CMD_READ, $urandom_range(0, LEN_TOP), base, $urandom_range(0, 1),
                       reply);
               phase_items++;
            end else begin
               // noise: any command, any fields
               cmd = cmd_type'($urandom_range(0, 3));
               send_op(cmd, $urandom_range(0, LEN_TOP), $urandom_range(0, PAGE_TOP),
                       $urandom_range(0, 1), reply);
               if (cmd != CMD_UNUSED)
                  phase_items++;
            end
         end
      end

      quiet = 1'b0;
      wait_replies_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_replies.size() == 0)
         $display("[bitmap_run_allocator] OK");
      else
         $display("[bitmap_run_allocator] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
sv/bra_pkg.sv
sv/bra_req_if.sv
sv/bra_rsp_if.sv
sv/bra_scan_step.sv
sv/bitmap_run_allocator.sv
tb/sv/bitmap_run_allocator_tb.sv
